// ===== hw/rtl/mrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared types and constants of the modal resonator biquad bank.
// ----------------------------------------------------------------------------
package mrb_pkg;

    localparam int FRAC_BITS = 20;
    localparam int YW        = 24;   // partial output, Q4.20 clamped to +/-4
    localparam int ADDR_BITS = 8;
    localparam int OUT_BITS  = 30;
    localparam int MODE_BITS = 2;
    localparam int CFG_BITS  = 23;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SAMPLE   = 2'd0,
        MODE_COEF     = 2'd1,
        MODE_ACTIVATE = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    localparam logic [1:0] CFG_PARTIAL_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SILENCE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_SILENCE_THRESH = 2'd2;

    localparam logic signed [65:0] FWD_LIM   = 66'sh2000000000000000;
    localparam logic signed [65:0] ROUND_ADD = 66'sd524288;
    localparam logic signed [65:0] Y_LIM     = 66'sd4194304;
    localparam logic signed [35:0] OUT_LIM   = 36'sd268435456;

    typedef struct packed {
        logic                 rd;
        logic                 mul0;
        logic                 add0;
        logic                 mul1;
        logic                 add1;
        logic                 wr;
        logic                 clr_one;
        logic                 clr_all;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] clr_addr;
    } lane_ctl_t;

    typedef struct packed {
        logic clr;
        logic add;
        logic fin;
    } merge_ctl_t;

endpackage

// ===== hw/rtl/modal_resonator_biquad_bank.sv =====
// A sample word on an active bank runs through the N partials in use, one after
// another; for each partial the RAM read, two multiply/round pairs and history
// write-back, then sum, silence test, output. No new word is taken while a sample
// word is in flight, and its result waits while the last result word is not taken
// by m_tready. Reset clears the RAM valid bits, so all read as zero; rst_n is
// async, active low, sets defaults.
// ----------------------------------------------------------------------------
// modal_resonator_biquad_bank
// Bank of band-pass biquads, left and right lanes in parallel, summed outputs
// and silence-driven shutdown.
// ----------------------------------------------------------------------------
module modal_resonator_biquad_bank import mrb_pkg::*; #(
    parameter int PARTIALS    = 64,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // partial_index, coef_b0, coef_a1, coef_a2, clear_history,
    // sample_l0, sample_r0, sample_l1, sample_r1, zero fill
    input  logic [((7 + 3*COEF_BITS + 4*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // mode
    input  logic [MODE_BITS-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_l0, out_r0, out_l1, out_r1, still_active, zero fill
    output logic [127:0]        m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int IDXW = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
    localparam int CNTW = $clog2(PARTIALS + 1);
    localparam int CW   = COEF_BITS;
    localparam int SW   = SAMPLE_BITS;
    localparam int CRW  = 3 * CW;
    localparam int XO   = 7 + 3 * CW;   // first sample bit in s_tdata

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN,
        ST_DEC,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [2:0]             ph_reg;
    logic [IDXW-1:0]        part_reg;
    logic [CNTW-1:0]        n_reg;
    logic                   active_reg;
    logic [15:0]            quiet_reg;
    logic                   zero_reg;
    logic [6:0]             pcount_reg;
    logic [15:0]            limit_reg;
    logic [CFG_BITS-1:0]    thresh_reg;
    logic [PARTIALS-1:0]    cvalid_reg;
    logic                   cv_reg;
    logic                   m_tvalid_reg;
    logic [127:0]           m_tdata_reg;
    logic signed [SW-1:0]   xl0_reg;
    logic signed [SW-1:0]   xr0_reg;
    logic signed [SW-1:0]   xl1_reg;
    logic signed [SW-1:0]   xr1_reg;

    logic                   s_acc;
    mode_t                  mode;
    logic [8:0]             idx_ext;
    logic                   idx_ok;
    logic                   coef_we;
    logic [IDXW-1:0]        coef_waddr;
    logic [CRW-1:0]         coef_rdata;
    logic signed [CW-1:0]   b0;
    logic signed [CW-1:0]   a1;
    logic signed [CW-1:0]   a2;
    logic [CNTW-1:0]        n_sat;
    logic [16:0]            quiet_next;
    logic                   clear_now;
    lane_ctl_t              lctl;
    merge_ctl_t             mctl;
    logic signed [YW-1:0]   yl0;
    logic signed [YW-1:0]   yl1;
    logic signed [YW-1:0]   yr0;
    logic signed [YW-1:0]   yr1;
    logic signed [OUT_BITS-1:0] sl0;
    logic signed [OUT_BITS-1:0] sr0;
    logic signed [OUT_BITS-1:0] sl1;
    logic signed [OUT_BITS-1:0] sr1;
    logic                   loud;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign mode      = mode_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign idx_ext    = {3'b000, s_tdata[5:0]};
    assign idx_ok     = idx_ext < 9'(PARTIALS);
    assign coef_waddr = IDXW'(idx_ext);
    assign coef_we    = s_acc && (mode == MODE_COEF) && idx_ok;

    assign n_sat = ({2'b00, pcount_reg} > 9'(PARTIALS)) ? CNTW'(PARTIALS)
                                                        : CNTW'(pcount_reg);

    // coefficients of an unwritten partial read as zero
    assign b0 = cv_reg ? coef_rdata[CW-1:0] : '0;
    assign a1 = cv_reg ? coef_rdata[2*CW-1:CW] : '0;
    assign a2 = cv_reg ? coef_rdata[CRW-1:2*CW] : '0;

    assign quiet_next = loud ? 17'd0 : ({1'b0, quiet_reg} + 17'd1);
    assign clear_now  = quiet_next >= {1'b0, limit_reg};

    always_comb
    begin
        lctl          = '0;
        lctl.addr     = ADDR_BITS'(part_reg);
        lctl.clr_addr = ADDR_BITS'(coef_waddr);
        lctl.clr_one  = coef_we && s_tdata[XO-1];
        lctl.clr_all  = (state_reg == ST_DEC) && clear_now;
        if (state_reg == ST_RUN)
        begin
            lctl.rd   = (ph_reg == 3'd0);
            lctl.mul0 = (ph_reg == 3'd1);
            lctl.add0 = (ph_reg == 3'd2);
            lctl.mul1 = (ph_reg == 3'd3);
            lctl.add1 = (ph_reg == 3'd4);
            lctl.wr   = (ph_reg == 3'd5);
        end
        mctl.clr = s_acc && (mode == MODE_SAMPLE);
        mctl.add = lctl.wr;
        mctl.fin = (state_reg == ST_FIN);
    end

    mrb_ram #(
        .WIDTH (CRW),
        .DEPTH (PARTIALS)
    ) u_coef (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (s_tdata[6+CRW-1:6]),
        .re    (lctl.rd),
        .raddr (part_reg),
        .rdata (coef_rdata)
    );

    mrb_lane #(
        .PARTIALS    (PARTIALS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_lane_l (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lctl),
        .b0    (b0),
        .a1    (a1),
        .a2    (a2),
        .x0    (xl0_reg),
        .x1    (xl1_reg),
        .y0    (yl0),
        .y1    (yl1)
    );

    mrb_lane #(
        .PARTIALS    (PARTIALS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_lane_r (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lctl),
        .b0    (b0),
        .a1    (a1),
        .a2    (a2),
        .x0    (xr0_reg),
        .x1    (xr1_reg),
        .y0    (yr0),
        .y1    (yr1)
    );

    mrb_merge #(
        .PARTIALS    (PARTIALS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mctl),
        .y_l0      (yl0),
        .y_r0      (yr0),
        .y_l1      (yl1),
        .y_r1      (yr1),
        .x_l0      (xl0_reg),
        .x_r0      (xr0_reg),
        .x_l1      (xl1_reg),
        .x_r1      (xr1_reg),
        .threshold (thresh_reg),
        .out_l0    (sl0),
        .out_r0    (sr0),
        .out_l1    (sl1),
        .out_r1    (sr1),
        .loud      (loud)
    );

    always_ff @(posedge clk)
    begin
        if (s_acc && (mode == MODE_SAMPLE))
        begin
            xl0_reg <= s_tdata[XO+SW-1:XO];
            xr0_reg <= s_tdata[XO+2*SW-1:XO+SW];
            xl1_reg <= s_tdata[XO+3*SW-1:XO+2*SW];
            xr1_reg <= s_tdata[XO+4*SW-1:XO+3*SW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 7'd16;
            limit_reg  <= 16'd48000;
            thresh_reg <= CFG_BITS'(10);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PARTIAL_COUNT:  pcount_reg <= cfg_data[6:0];
                CFG_SILENCE_LIMIT:  limit_reg  <= cfg_data[15:0];
                CFG_SILENCE_THRESH: thresh_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ph_reg       <= 3'd0;
            part_reg     <= '0;
            n_reg        <= '0;
            active_reg   <= 1'b0;
            quiet_reg    <= 16'd0;
            zero_reg     <= 1'b0;
            cvalid_reg   <= '0;
            cv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // the output state handles its own hand-over of the result word
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (coef_we)
            begin
                cvalid_reg[coef_waddr] <= 1'b1;
            end
            if (lctl.rd)
            begin
                cv_reg <= cvalid_reg[part_reg];
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        unique case (mode)
                            MODE_ACTIVATE:
                            begin
                                if (!active_reg)
                                begin
                                    active_reg <= 1'b1;
                                    quiet_reg  <= 16'd0;
                                end
                            end
                            MODE_SAMPLE:
                            begin
                                part_reg <= '0;
                                ph_reg   <= 3'd0;
                                n_reg    <= n_sat;
                                zero_reg <= !active_reg;
                                if (!active_reg)
                                begin
                                    state_reg <= ST_OUT;
                                end
                                else if (n_sat == '0)
                                begin
                                    state_reg <= ST_FIN;
                                end
                                else
                                begin
                                    state_reg <= ST_RUN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN:
                begin
                    if (ph_reg == 3'd5)
                    begin
                        ph_reg <= 3'd0;
                        if ((CNTW'(part_reg) + CNTW'(1)) == n_reg)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            part_reg <= part_reg + IDXW'(1);
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                ST_FIN:
                begin
                    state_reg <= ST_DEC;
                end
                ST_DEC:
                begin
                    // silence reached: drop history and go inactive
                    if (clear_now)
                    begin
                        active_reg <= 1'b0;
                        quiet_reg  <= 16'd0;
                    end
                    else
                    begin
                        quiet_reg <= quiet_next[15:0];
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (zero_reg)
                        begin
                            m_tdata_reg <= '0;
                        end
                        else
                        begin
                            m_tdata_reg <= {7'd0, active_reg, sr1, sl1, sr0, sl0};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (ph_reg <= 3'd5) && (CNTW'(part_reg) < n_reg))
        else $error("partial sequencer out of range");

    a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (quiet_reg == 16'd0))
        else $error("quiet count moved while bank inactive");

    a_silence_off: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DEC) && clear_now) |=> !active_reg)
        else $error("bank stayed active after silence limit");

    a_inactive_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (mode == MODE_SAMPLE) && !active_reg) |=> (state_reg == ST_OUT))
        else $error("inactive sample word did not go straight to output");
`endif

endmodule

// ===== hw/rtl/mrb_ram.sv =====
// ----------------------------------------------------------------------------
// mrb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrb_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/mrb_lane.sv =====
// ----------------------------------------------------------------------------
// mrb_lane
// One channel of the bank: shared biquad core stepping through the partials,
// two frames in series per partial, history held in a RAM.
// ----------------------------------------------------------------------------
module mrb_lane import mrb_pkg::*; #(
    parameter int PARTIALS    = 64,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lane_ctl_t                     ctl,
    input  logic signed [COEF_BITS-1:0]   b0,
    input  logic signed [COEF_BITS-1:0]   a1,
    input  logic signed [COEF_BITS-1:0]   a2,
    input  logic signed [SAMPLE_BITS-1:0] x0,
    input  logic signed [SAMPLE_BITS-1:0] x1,
    output logic signed [YW-1:0]          y0,
    output logic signed [YW-1:0]          y1
);

    localparam int IDXW = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
    localparam int SW   = SAMPLE_BITS;
    localparam int HW   = 2 * SW + 2 * YW;
    localparam int DW   = SW + 1;
    localparam int PFW  = COEF_BITS + DW;
    localparam int PAW  = COEF_BITS + YW;

    logic [PARTIALS-1:0]    valid_reg;
    logic                   hv_reg;
    logic [HW-1:0]          rdata;
    logic [HW-1:0]          wdata;
    logic signed [SW-1:0]   hx1;
    logic signed [SW-1:0]   hx2;
    logic signed [YW-1:0]   hy1;
    logic signed [YW-1:0]   hy2;
    logic signed [DW-1:0]   diff0;
    logic signed [DW-1:0]   diff1;
    logic signed [PFW-1:0]  pf_reg;
    logic signed [PAW-1:0]  pa1_reg;
    logic signed [PAW-1:0]  pa2_reg;
    logic signed [YW-1:0]   y0_reg;
    logic signed [YW-1:0]   y1_reg;

    function automatic logic signed [YW-1:0] round_clamp(
        input logic signed [PFW-1:0] f,
        input logic signed [PAW-1:0] p1,
        input logic signed [PAW-1:0] p2
    );
        logic signed [65:0] fe;
        logic signed [65:0] acc;
        begin
            fe = 66'(f);
            if (fe > FWD_LIM)
            begin
                fe = FWD_LIM;
            end
            else if (fe < -FWD_LIM)
            begin
                fe = -FWD_LIM;
            end
            acc = fe - 66'(p1) - 66'(p2) + ROUND_ADD;
            acc = acc >>> FRAC_BITS;
            if (acc > Y_LIM)
            begin
                acc = Y_LIM;
            end
            else if (acc < -Y_LIM)
            begin
                acc = -Y_LIM;
            end
            return YW'(acc);
        end
    endfunction

    mrb_ram #(
        .WIDTH (HW),
        .DEPTH (PARTIALS)
    ) u_hist (
        .clk   (clk),
        .we    (ctl.wr),
        .waddr (ctl.addr[IDXW-1:0]),
        .wdata (wdata),
        .re    (ctl.rd),
        .raddr (ctl.addr[IDXW-1:0]),
        .rdata (rdata)
    );

    // unwritten or cleared history reads as zero
    assign hx1 = hv_reg ? rdata[SW-1:0] : '0;
    assign hx2 = hv_reg ? rdata[2*SW-1:SW] : '0;
    assign hy1 = hv_reg ? rdata[2*SW+YW-1:2*SW] : '0;
    assign hy2 = hv_reg ? rdata[HW-1:2*SW+YW] : '0;

    assign diff0 = DW'(x0) - DW'(hx2);
    assign diff1 = DW'(x1) - DW'(hx1);

    assign wdata = {y0_reg, y1_reg, x0, x1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hv_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else
            begin
                if (ctl.clr_one)
                begin
                    valid_reg[ctl.clr_addr[IDXW-1:0]] <= 1'b0;
                end
                if (ctl.wr)
                begin
                    valid_reg[ctl.addr[IDXW-1:0]] <= 1'b1;
                end
            end
            if (ctl.rd)
            begin
                hv_reg <= valid_reg[ctl.addr[IDXW-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul0)
        begin
            pf_reg  <= PFW'(b0) * PFW'(diff0);
            pa1_reg <= PAW'(a1) * PAW'(hy1);
            pa2_reg <= PAW'(a2) * PAW'(hy2);
        end
        else if (ctl.mul1)
        begin
            pf_reg  <= PFW'(b0) * PFW'(diff1);
            pa1_reg <= PAW'(a1) * PAW'(y0_reg);
            pa2_reg <= PAW'(a2) * PAW'(hy1);
        end
        if (ctl.add0)
        begin
            y0_reg <= round_clamp(pf_reg, pa1_reg, pa2_reg);
        end
        if (ctl.add1)
        begin
            y1_reg <= round_clamp(pf_reg, pa1_reg, pa2_reg);
        end
    end

    assign y0 = y0_reg;
    assign y1 = y1_reg;

endmodule

// ===== hw/rtl/mrb_merge.sv =====
// ----------------------------------------------------------------------------
// mrb_merge
// Sums the lane outputs over the partials in use, saturates and tests for silence.
// ----------------------------------------------------------------------------
module mrb_merge import mrb_pkg::*; #(
    parameter int PARTIALS    = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  merge_ctl_t                    ctl,
    input  logic signed [YW-1:0]          y_l0,
    input  logic signed [YW-1:0]          y_r0,
    input  logic signed [YW-1:0]          y_l1,
    input  logic signed [YW-1:0]          y_r1,
    input  logic signed [SAMPLE_BITS-1:0] x_l0,
    input  logic signed [SAMPLE_BITS-1:0] x_r0,
    input  logic signed [SAMPLE_BITS-1:0] x_l1,
    input  logic signed [SAMPLE_BITS-1:0] x_r1,
    input  logic [CFG_BITS-1:0]           threshold,
    output logic signed [OUT_BITS-1:0]    out_l0,
    output logic signed [OUT_BITS-1:0]    out_r0,
    output logic signed [OUT_BITS-1:0]    out_l1,
    output logic signed [OUT_BITS-1:0]    out_r1,
    output logic                          loud
);

    localparam int SUMW = YW + $clog2(PARTIALS + 1) + 8;
    localparam int LW   = 36;

    logic signed [SUMW-1:0]     sum_reg [4];
    logic signed [YW-1:0]       y_in    [4];
    logic signed [SAMPLE_BITS-1:0] x_in [4];
    logic signed [LW-1:0]       sat     [4];
    logic [3:0]                 hot;
    logic signed [OUT_BITS-1:0] out_reg [4];
    logic                       loud_reg;

    assign y_in[0] = y_l0;
    assign y_in[1] = y_r0;
    assign y_in[2] = y_l1;
    assign y_in[3] = y_r1;
    assign x_in[0] = x_l0;
    assign x_in[1] = x_r0;
    assign x_in[2] = x_l1;
    assign x_in[3] = x_r1;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [LW-1:0] s;
            logic signed [LW-1:0] ax;
            s = LW'(sum_reg[i]);
            if (s > OUT_LIM)
            begin
                s = OUT_LIM;
            end
            else if (s < -OUT_LIM)
            begin
                s = -OUT_LIM;
            end
            sat[i] = s;
            ax = LW'(x_in[i]);
            if (ax < 0)
            begin
                ax = -ax;
            end
            if (s < 0)
            begin
                s = -s;
            end
            hot[i] = (s + ax) > $signed(LW'(threshold));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loud_reg <= 1'b0;
        end
        else if (ctl.fin)
        begin
            loud_reg <= |hot;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (ctl.clr)
            begin
                sum_reg[i] <= '0;
            end
            else if (ctl.add)
            begin
                sum_reg[i] <= sum_reg[i] + SUMW'(y_in[i]);
            end
            if (ctl.fin)
            begin
                out_reg[i] <= OUT_BITS'(sat[i]);
            end
        end
    end

    assign out_l0 = out_reg[0];
    assign out_r0 = out_reg[1];
    assign out_l1 = out_reg[2];
    assign out_r1 = out_reg[3];
    assign loud   = loud_reg;

endmodule

// ===== test/mrb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_checker
// Watches the word, register and result channels of the resonator bank, keeps
// its own fixed-point model of every partial, and compares each result word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mrb_checker import mrb_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [175:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [22:0]  cfg_data,
    output int           errors,
    output int           pending,
    output int           frames_checked
);

    localparam int NP = 64;

    typedef struct packed {
        logic [29:0] l0;
        logic [29:0] r0;
        logic [29:0] l1;
        logic [29:0] r1;
        logic        act;
    } bank_out_t;

    longint      b0_m [NP];
    longint      a1_m [NP];
    longint      a2_m [NP];
    longint      xin1 [NP][2];
    longint      xin2 [NP][2];
    longint      yout1 [NP][2];
    longint      yout2 [NP][2];
    bit          active;
    int unsigned quiet;
    int unsigned pc;
    int unsigned lim;
    int unsigned thr;
    bank_out_t   expected_frames[$];

    assign pending = expected_frames.size();

    function automatic longint sx24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // one band-pass section: exact Q.40 sum, round half up, clamp to +/-4.0
    function automatic longint resonate(longint b0, longint a1, longint a2,
                                        longint x, longint x2, longint y1, longint y2);
        longint acc;
        acc = b0 * (x - x2) - a1 * y1 - a2 * y2 + 64'sd524288;
        acc = acc >>> 20;
        return clip(acc, -64'sd4194304, 64'sd4194304);
    endfunction

    task automatic clear_hist(int p);
        for (int c = 0; c < 2; c++)
        begin
            xin1[p][c] = 0;
            xin2[p][c] = 0;
            yout1[p][c] = 0;
            yout2[p][c] = 0;
        end
    endtask

    task automatic bank_reset();
        for (int p = 0; p < NP; p++)
        begin
            b0_m[p] = 0;
            a1_m[p] = 0;
            a2_m[p] = 0;
            clear_hist(p);
        end
        active = 0;
        quiet  = 0;
        pc     = 16;
        lim    = 48000;
        thr    = 10;
        expected_frames.delete();
    endtask

    task automatic bank_step(mode_t m, logic [175:0] d);
        longint    x [4];
        longint    sum [4];
        longint    y0;
        longint    y1;
        int        n;
        int        p;
        bit        loud;
        bank_out_t r;
        case (m)
            MODE_COEF:
            begin
                p = d[5:0];
                b0_m[p] = sx24(d[29:6]);
                a1_m[p] = sx24(d[53:30]);
                a2_m[p] = sx24(d[77:54]);
                if (d[78])
                    clear_hist(p);
            end
            MODE_ACTIVATE:
            begin
                if (!active)
                begin
                    active = 1;
                    quiet  = 0;
                end
            end
            MODE_SAMPLE:
            begin
                if (!active)
                begin
                    expected_frames.push_back('0);
                    return;
                end
                x[0] = sx24(d[102:79]);
                x[1] = sx24(d[126:103]);
                x[2] = sx24(d[150:127]);
                x[3] = sx24(d[174:151]);
                for (int i = 0; i < 4; i++)
                    sum[i] = 0;
                n = pc > NP ? NP : pc;
                for (p = 0; p < n; p++)
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        y0 = resonate(b0_m[p], a1_m[p], a2_m[p], x[c], xin2[p][c],
                                      yout1[p][c], yout2[p][c]);
                        y1 = resonate(b0_m[p], a1_m[p], a2_m[p], x[2+c], xin1[p][c],
                                      y0, yout1[p][c]);
                        xin2[p][c]  = x[c];
                        xin1[p][c]  = x[2+c];
                        yout2[p][c] = y0;
                        yout1[p][c] = y1;
                        sum[c]   += y0;
                        sum[2+c] += y1;
                    end
                end
                loud = 0;
                for (int i = 0; i < 4; i++)
                begin
                    sum[i] = clip(sum[i], -64'sd268435456, 64'sd268435456);
                    if (mag(sum[i]) + mag(x[i]) > longint'(thr))
                        loud = 1;
                end
                quiet = loud ? 0 : quiet + 1;
                if (quiet >= lim)
                begin
                    active = 0;
                    for (int q = 0; q < NP; q++)
                        clear_hist(q);
                    quiet = 0;
                end
                r.l0  = sum[0][29:0];
                r.r0  = sum[1][29:0];
                r.l1  = sum[2][29:0];
                r.r1  = sum[3][29:0];
                r.act = active;
                expected_frames.push_back(r);
            end
            default: ;  // unused mode: drop
        endcase
    endtask

    task automatic check_field(string name, logic [29:0] want, logic [29:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bank_out_t e;
        if (!rst_n)
        begin
            bank_reset();
            errors = 0;
            frames_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PARTIAL_COUNT:  pc  = cfg_data[6:0];
                    CFG_SILENCE_LIMIT:  lim = cfg_data[15:0];
                    CFG_SILENCE_THRESH: thr = cfg_data[22:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                frames_checked++;
                if (expected_frames.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with none expected, actual %h", $time,
                             m_tdata);
                end
                else
                begin
                    e = expected_frames.pop_front();
                    check_field("out_l0", e.l0, m_tdata[29:0]);
                    check_field("out_r0", e.r0, m_tdata[59:30]);
                    check_field("out_l1", e.l1, m_tdata[89:60]);
                    check_field("out_r1", e.r1, m_tdata[119:90]);
                    check_field("still_active", {29'd0, e.act}, {29'd0, m_tdata[120]});
                end
            end
            if (s_tvalid && s_tready)
                bank_step(mode_t'(s_tuser), s_tdata);
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the resonator bank with directed and random words over a series of
// register settings, with random gaps and back-pressure; the checker module
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    import mrb_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 420;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic [1:0]   s_tuser = MODE_SAMPLE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_PARTIAL_COUNT;
    logic [22:0]  cfg_data = '0;

    int errors;
    int pending;
    int frames_checked;
    int words_sent;
    int settings_used;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit no_gap;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    modal_resonator_biquad_bank u_top (.*);

    mrb_checker u_checker (.*);

    // receiver stall: draw a wait after each result word
    always @(posedge clk)
    begin
        int w;
        if (m_tvalid && m_tready)
        begin
            w = no_gap ? 0 : $urandom_range(0, 3);
            rx_wait  <= w;
            m_tready <= (w == 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [175:0] pack_word(logic [5:0] idx, logic [23:0] b0,
                                               logic [23:0] a1, logic [23:0] a2,
                                               logic clr, logic [23:0] l0, logic [23:0] r0,
                                               logic [23:0] l1, logic [23:0] r1);
        return {1'b0, r1, l1, r0, l0, clr, a2, a1, b0, idx};
    endfunction

    task automatic send(mode_t m, logic [175:0] d);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // hold until every result is back, then wait a settling period with no words sent
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [22:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_bank(int pc, int lim, int thr);
        write_reg(CFG_PARTIAL_COUNT, pc);
        write_reg(CFG_SILENCE_LIMIT, lim);
        write_reg(CFG_SILENCE_THRESH, thr);
        settings_used++;
    endtask

    function automatic logic [23:0] rand_sample();
        logic [23:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 8191) - 4096;
            2: v = '0;
            default: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
        return v;
    endfunction

    task automatic rand_word();
        int          k;
        logic [23:0] b0;
        logic [23:0] a1;
        logic [23:0] a2;
        k = $urandom_range(0, 99);
        if (k < 62)
        begin
            send(MODE_SAMPLE, pack_word($urandom, $urandom, $urandom, $urandom, $urandom,
                                        rand_sample(), rand_sample(), rand_sample(),
                                        rand_sample()));
        end
        else if (k < 88)
        begin
            if ($urandom_range(0, 1))
            begin
                // ringing but stable section
                b0 = $urandom_range(0, 200000) - 100000;
                a2 = $urandom_range(900000, 1040000);
                a1 = $urandom_range(0, 3800000) - 1900000;
            end
            else
            begin
                b0 = $urandom;
                a1 = $urandom;
                a2 = $urandom;
            end
            send(MODE_COEF, pack_word($urandom, b0, a1, a2, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
        end
        else if (k < 94)
        begin
            send(MODE_ACTIVATE, pack_word($urandom, $urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom, $urandom));
        end
        else
        begin
            send(MODE_UNUSED, pack_word($urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    initial
    begin
        int pcs  [6] = '{5, 0, 127, 3, 7, 1};
        int lims [6] = '{1000, 2, 3, 0, 65535, 4};
        int thrs [6] = '{10, 100, 8388607, 50, 0, 5000};
        int cnts [6] = '{330, 300, 80, 300, 330, 300};
        words_sent = 0;
        settings_used = 0;
        no_gap = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset settings
        send(MODE_SAMPLE, pack_word(0, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000, 1, 24'hFFFFFF));
        send(MODE_ACTIVATE, '0);
        send(MODE_ACTIVATE, '0);
        send(MODE_COEF, pack_word(0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1, 0, 0, 0, 0));
        send(MODE_COEF, pack_word(63, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0));
        send(MODE_COEF, pack_word(1, 24'd50000, -24'sd1800000, 24'd1000000, 0, 0, 0, 0, 0));
        send(MODE_COEF, pack_word(2, 24'h800000, 24'h800000, 24'h800000, 1, 0, 0, 0, 0));
        send(MODE_UNUSED, {176{1'b1}});
        send(MODE_SAMPLE, pack_word(0, 0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                                    24'h800000));
        send(MODE_SAMPLE, pack_word(0, 0, 0, 0, 0, 24'h800000, 24'h800000, 24'h7FFFFF,
                                    24'h7FFFFF));
        send(MODE_SAMPLE, '0);
        send(MODE_COEF, pack_word(1, 24'd50000, -24'sd1800000, 24'd1000000, 1, 0, 0, 0, 0));
        send(MODE_SAMPLE, pack_word(0, 0, 0, 0, 0, 24'd1, -24'sd1, 24'd4096, 24'd0));
        send(MODE_SAMPLE, pack_word(0, 0, 0, 0, 0, 24'd5, 24'd0, 24'd0, 24'd0));
        send(MODE_SAMPLE, '0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            no_gap = (ph == 2) || (ph == 4);
            set_bank(pcs[ph], lims[ph], thrs[ph]);
            send(MODE_ACTIVATE, '0);
            for (int i = 0; i < cnts[ph]; i++)
            begin
                // runs of near-silence let the quiet counter reach its limit
                if ($urandom_range(0, 3) == 0)
                    send(MODE_SAMPLE, pack_word(0, 0, 0, 0, 0, $urandom_range(0, 3), 0, 0,
                                                0));
                else
                    rand_word();
            end
            drain();
        end
        set_bank(16, 48000, 10);

        $display("Sent %0d words under %0d register settings, %0d result words compared",
                 words_sent, settings_used, frames_checked);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== modal_resonator_biquad_bank.f =====
hw/rtl/mrb_pkg.sv
hw/rtl/mrb_ram.sv
hw/rtl/mrb_lane.sv
hw/rtl/mrb_merge.sv
hw/rtl/modal_resonator_biquad_bank.sv
test/mrb_checker.sv
test/tb.sv
